FILE: src/vti_pkg.sv
`default_nettype none

package vti_pkg;

    localparam logic [15:0] TPID_CTAG = 16'h8100;
    localparam logic [15:0] TPID_STAG = 16'h88A8;

    // Frame byte positions seen by the front end.
    localparam logic [3:0] POS_TYPE_HI = 4'd12;
    localparam logic [3:0] POS_TYPE_LO = 4'd13;
    localparam logic [3:0] POS_DONE    = 4'd14;

    localparam int QUEUE_DEPTH = 2;

    // Output beat sequence of one tag command.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_TPID_HI = 3'd0;
    localparam logic [STEP_W-1:0] STEP_TPID_LO = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TCI_HI  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_TCI_LO  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_BYTE_A  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_BYTE_B  = 3'd5;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_TAG_END,
        CMD_TAG_FULL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        stag;
        logic [7:0]  held;
        logic [7:0]  data;
        logic        last;
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/vti_in_if.sv
`default_nettype none

interface vti_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: src/vti_out_if.sv
`default_nettype none

interface vti_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: src/vti_cfg_if.sv
`default_nettype none

interface vti_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] tag_control;

    modport source (output valid, output tag_control, input ready);
    modport sink (input valid, input tag_control, output ready);
endinterface

`default_nettype wire

FILE: src/vti_front.sv
`default_nettype none

module vti_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    vti_in_if.sink             rx,
    input  wire logic          q_full,
    output logic               push,
    output vti_pkg::cmd_t      push_cmd
);
    import vti_pkg::*;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        push_cmd.kind = CMD_PASS;
        push_cmd.stag = 1'b0;
        push_cmd.held = held_reg;
        push_cmd.data = rx.data_byte;
        push_cmd.last = rx.last_byte;
        push          = accept;
        pos_next      = pos_reg;
        held_next     = held_reg;

        if (pos_reg < POS_TYPE_HI) begin
            pos_next = pos_reg + 4'd1;
        end
        else if (pos_reg == POS_TYPE_HI) begin
            if (rx.last_byte) begin
                push_cmd.kind = CMD_TAG_END;
            end
            else begin
                // Byte 12 waits here until the second type byte shows up.
                push      = 1'b0;
                held_next = rx.data_byte;
                pos_next  = POS_TYPE_LO;
            end
        end
        else if (pos_reg == POS_TYPE_LO) begin
            push_cmd.kind = CMD_TAG_FULL;
            push_cmd.stag = ({held_reg, rx.data_byte} == TPID_CTAG);
            pos_next      = POS_DONE;
        end
        else begin
            pos_next = POS_DONE;
        end

        if (rx.last_byte) begin
            pos_next  = 4'd0;
            held_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= 4'd0;
            held_reg <= 8'd0;
        end
        else if (accept) begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= POS_DONE)
        else $error("front byte position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx.last_byte) |=> (pos_reg == 4'd0 && held_reg == 8'd0))
        else $error("frame state not cleared after last beat");

endmodule

`default_nettype wire

FILE: src/vti_queue.sv
`default_nettype none

module vti_queue #(
    parameter int DEPTH = vti_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire vti_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output vti_pkg::cmd_t      head_cmd,
    output logic               full,
    output logic               empty
);
    import vti_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entries[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

FILE: src/vti_back.sv
`default_nettype none

module vti_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vti_pkg::cmd_t head_cmd,
    input  wire logic          q_empty,
    input  wire logic [15:0]   tci,
    output logic               pop,
    vti_out_if.source          tx
);
    import vti_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              load;
    logic              beat_final;
    logic [15:0]       tpid;

    assign tx.valid    = out_valid_reg;
    assign tx.out_byte = out_byte_reg;
    assign tx.out_last = out_last_reg;

    // The output register takes a queued beat whenever it is empty or being drained.
    assign load = !q_empty && (!out_valid_reg || tx.ready);
    assign pop  = load && beat_final;
    assign tpid = head_cmd.stag ? TPID_STAG : TPID_CTAG;

    always_comb
    begin
        out_byte_next = head_cmd.data;
        out_last_next = 1'b0;
        beat_final    = 1'b0;
        if (head_cmd.kind == CMD_PASS) begin
            out_last_next = head_cmd.last;
            beat_final    = 1'b1;
        end
        else begin
            unique case (step_reg)
                STEP_TPID_HI: out_byte_next = tpid[15:8];
                STEP_TPID_LO: out_byte_next = tpid[7:0];
                STEP_TCI_HI:  out_byte_next = tci[15:8];
                STEP_TCI_LO:  out_byte_next = tci[7:0];
                STEP_BYTE_A:
                begin
                    if (head_cmd.kind == CMD_TAG_END) begin
                        out_byte_next = head_cmd.data;
                        out_last_next = 1'b1;
                        beat_final    = 1'b1;
                    end
                    else begin
                        out_byte_next = head_cmd.held;
                    end
                end
                STEP_BYTE_B:
                begin
                    out_byte_next = head_cmd.data;
                    out_last_next = head_cmd.last;
                    beat_final    = 1'b1;
                end
                default:
                begin
                    out_byte_next = head_cmd.data;
                    beat_final    = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
            step_next      = beat_final ? STEP_TPID_HI : step_reg + 1'b1;
        end
        else if (tx.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg <= out_byte_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= STEP_TPID_HI;
            out_valid_reg <= 1'b0;
        end
        else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) step_reg <= STEP_BYTE_B)
        else $error("back end step out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != STEP_TPID_HI) |-> (!q_empty && head_cmd.kind != CMD_PASS))
        else $error("tag sequence running without a tag command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_BYTE_B) |-> (head_cmd.kind == CMD_TAG_FULL))
        else $error("second type byte step on a short tag command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load && !beat_final) |=> (out_valid_reg && !out_last_reg))
        else $error("inner beat of a tag sequence marked last");

endmodule

`default_nettype wire

FILE: src/vlan_tag_inserter.sv
// VLAN tag inserter for an Ethernet byte stream.
// rx carries frame bytes in wire order (data_byte, last_byte on the final beat).
// tx carries the tagged frame (out_byte, out_last). Both use valid/ready.
// cfg writes the 16-bit TCI; it is always ready and should only be written
// while no frame is in flight. The TPID is 0x88A8 when the frame's own type
// field is 0x8100, else 0x8100; frames shorter than 13 bytes pass unchanged.
// A front end classifies each input beat and pushes a command into a small
// queue; the back end expands each command into one to six output beats.
// An input beat is stored in the queue, then in the output register; byte
// 12 is held until byte 13 arrives. The block accepts one byte per cycle
// while the queue has room and emits one byte per cycle while tx is ready;
// the four tag beats per frame are added; rx stalls once the queue fills.
// When tx stalls, the output register holds its beat, the queue fills and
// rx.ready drops. Reset clears the TCI to zero, empties the queue and
// returns the front end to the start of a frame.
`default_nettype none

module vlan_tag_inserter #(
    parameter int QUEUE_DEPTH = vti_pkg::QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vti_in_if.sink    rx,
    vti_out_if.source tx,
    vti_cfg_if.sink   cfg
);
    import vti_pkg::*;

    logic [15:0] tci_reg;
    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    cmd_t        push_cmd;
    cmd_t        head_cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tci_reg <= 16'd0;
        end
        else if (cfg.valid && cfg.ready) begin
            tci_reg <= cfg.tag_control;
        end
    end

    vti_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    vti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    vti_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .tci      (tci_reg),
        .pop      (pop),
        .tx       (tx)
    );

endmodule

`default_nettype wire
